// ===== rtl/sorted_time_schedule_table_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SORTED_TIME_SCHEDULE_TABLE_DEFINES_SVH
`define SORTED_TIME_SCHEDULE_TABLE_DEFINES_SVH

// Same-cycle implication, muted while reset is low.
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is low.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Types, codes and widths shared by the sorted time schedule table.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int TableDepthDef = 32;
  localparam int TimeW         = 32;
  localparam int SlotW         = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } sts_op_e;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_REJECTED = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_DELETED  = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_DONE     = 3'd5
  } sts_status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } sts_state_e;

  // Broadcast to every cell in the execute cycle.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             clr;
    logic [TimeW-1:0] time_value;
    logic [SlotW-1:0] read_slot;
  } cell_cmd_t;

  // What one cell reports about its own entry.
  typedef struct packed {
    logic             hit;
    logic             at_pos;
    logic             eq;
    logic [TimeW-1:0] rd_data;
  } cell_flags_t;

  // Reduced view of the whole row.
  typedef struct packed {
    logic             found;
    logic [TimeW-1:0] rd_data;
  } match_t;

endpackage

// ===== rtl/sts_cell.sv =====
// ----------------------------------------------------------------------------
// sts_cell
// One table entry: compare against the broadcast time, shift with neighbours.
// ----------------------------------------------------------------------------
module sts_cell #(
  parameter int Idx    = 0,
  parameter bit IsLast = 1'b0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sts_pkg::cell_cmd_t        cmd_i,
  input  logic                      prev_hit_i,
  input  logic [sts_pkg::TimeW-1:0] prev_value_i,
  input  logic [sts_pkg::TimeW-1:0] next_value_i,
  output logic [sts_pkg::TimeW-1:0] value_o,
  output logic                      hit_o,
  output sts_pkg::cell_flags_t      flags_o
);
  import sts_pkg::*;

  logic [TimeW-1:0] value_q, value_d;
  logic             hit;
  logic             rd_sel;

  // Entry is at or after the search position.
  assign hit    = (value_q == '0) || (cmd_i.time_value <= value_q);
  assign rd_sel = (32'(cmd_i.read_slot) == 32'(Idx));

  always_comb begin
    value_d = value_q;
    if (IsLast) begin
      value_d = '0;                       // list terminator, always empty
    end else if (cmd_i.clr) begin
      value_d = '0;
    end else if (cmd_i.ins) begin
      if (prev_hit_i) begin
        value_d = prev_value_i;           // shift up
      end else if (hit) begin
        value_d = cmd_i.time_value;       // insertion point
      end
    end else if (cmd_i.del && hit) begin
      value_d = next_value_i;             // shift down
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o         = value_q;
  assign hit_o           = hit;
  assign flags_o.hit     = hit;
  assign flags_o.at_pos  = hit && !prev_hit_i;
  assign flags_o.eq      = (value_q == cmd_i.time_value);
  assign flags_o.rd_data = rd_sel ? value_q : '0;

endmodule

// ===== rtl/sts_collect.sv =====
// ----------------------------------------------------------------------------
// sts_collect
// Encode the one-hot search position and gather match and read data.
// ----------------------------------------------------------------------------
module sts_collect #(
  parameter int TableDepth = sts_pkg::TableDepthDef,
  localparam int PosW      = $clog2(TableDepth)
) (
  input  sts_pkg::cell_flags_t flags_i [TableDepth],
  output logic [PosW-1:0]      pos_o,
  output sts_pkg::match_t      match_o
);
  import sts_pkg::*;

  always_comb begin
    pos_o           = '0;
    match_o.found   = 1'b0;
    match_o.rd_data = '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (flags_i[i].at_pos) begin
        pos_o = pos_o | PosW'(i);
      end
      match_o.found   = match_o.found | (flags_i[i].at_pos & flags_i[i].eq);
      match_o.rd_data = match_o.rd_data | flags_i[i].rd_data;
    end
  end

endmodule

// ===== rtl/sorted_time_schedule_table.sv =====
// An input transfer is held in the input register, executed, and its result is
//   registered in the output register; no new item is taken until then. All
//   cells compare and shift together in the execute state.
// The execute cycle waits only while the output register holds an untaken result.
// Reset (rst_ni, asynchronous, active low) empties every entry and clears the
//   start threshold at once; no clearing pass follows.
// ----------------------------------------------------------------------------
// sorted_time_schedule_table
// Ascending list of event times kept in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module sorted_time_schedule_table #(
  parameter int TableDepth = sts_pkg::TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [31:0] time_value, [32] within_hours,
                                        // [37:33] read_slot, [39:38] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] op
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [4:0] slot_index, [36:5] entry_value,
                                        // [39:37] zero
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sts_pkg::*;

  localparam int PosW = $clog2(TableDepth);
  localparam logic [PosW-1:0] LastPos = PosW'(TableDepth - 1);

  // ---------------------------------------------------------------- config
  logic [TimeW-1:0] thr_q;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : thr_q;

  // The threshold answers at addresses 0 to 3; writes with paddr[2] set are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      thr_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------- control
  sts_state_e state_q, state_d;
  logic       s_acc;
  logic       out_free;
  logic       exec_en;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid_i) state_d = ST_EXEC;
      ST_EXEC: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    exec_en         = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_EXEC: exec_en = out_free;
      default: s_axis_tready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted item for the execute cycle.
  sts_op_e          op_q;
  logic [TimeW-1:0] time_q;
  logic             hours_q;
  logic [SlotW-1:0] rslot_q;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q    <= sts_op_e'(s_axis_tuser_i);
      time_q  <= s_axis_tdata_i[31:0];
      hours_q <= s_axis_tdata_i[32];
      rslot_q <= s_axis_tdata_i[37:33];
    end
  end

  // ---------------------------------------------------------------- cells
  cell_cmd_t        cmd;
  cell_flags_t      flags [TableDepth];
  logic [TimeW-1:0] values [TableDepth];
  logic             hits [TableDepth];
  logic [PosW-1:0]  pos;
  match_t           match;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    logic             prev_hit;
    logic [TimeW-1:0] prev_value;
    logic [TimeW-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_hit   = 1'b0;
      assign prev_value = '0;
    end else begin : g_mid
      assign prev_hit   = hits[i-1];
      assign prev_value = values[i-1];
    end

    if (i == TableDepth - 1) begin : g_end
      assign next_value = '0;
    end else begin : g_inner
      assign next_value = values[i+1];
    end

    sts_cell #(
      .Idx    (i),
      .IsLast (i == TableDepth - 1)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_hit_i   (prev_hit),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .value_o      (values[i]),
      .hit_o        (hits[i]),
      .flags_o      (flags[i])
    );
  end

  sts_collect #(
    .TableDepth (TableDepth)
  ) u_collect (
    .flags_i (flags),
    .pos_o   (pos),
    .match_o (match)
  );

  // ---------------------------------------------------------------- decide
  sts_status_e      status;
  logic [SlotW-1:0] slot;
  logic [TimeW-1:0] entry;
  logic             rejected;
  logic             full;
  logic             found;

  // A zero time is always rejected, since the threshold is never below zero.
  assign rejected = (time_q <= thr_q) || !hours_q;
  assign full     = (pos == LastPos);
  assign found    = match.found && (time_q != '0);

  always_comb begin
    status         = STAT_DONE;
    slot           = '0;
    entry          = '0;
    cmd.ins        = 1'b0;
    cmd.del        = 1'b0;
    cmd.clr        = 1'b0;
    cmd.time_value = time_q;
    cmd.read_slot  = rslot_q;
    unique case (op_q)
      OP_INSERT: begin
        if (rejected) begin
          status = STAT_REJECTED;
        end else if (full) begin
          status = STAT_FULL;
          slot   = SlotW'(pos);
        end else begin
          status  = STAT_INSERTED;
          slot    = SlotW'(pos);
          cmd.ins = exec_en;
        end
      end
      OP_DELETE: begin
        slot = SlotW'(pos);
        if (found) begin
          status  = STAT_DELETED;
          cmd.del = exec_en;
        end else begin
          status = STAT_NOTFOUND;
        end
      end
      OP_READ: begin
        slot  = rslot_q;
        entry = match.rd_data;
      end
      OP_CLEAR: begin
        cmd.clr = exec_en;
      end
      default: status = STAT_DONE;
    endcase
  end

  // ---------------------------------------------------------------- output
  logic             m_valid_q, m_valid_d;
  sts_status_e      status_q;
  logic [SlotW-1:0] slot_q;
  logic [TimeW-1:0] entry_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (exec_en) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      status_q <= status;
      slot_q   <= slot;
      entry_q  <= entry;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, entry_q, slot_q};
  assign m_axis_tuser_o  = status_q;

endmodule

// ===== rtl/sts_checker.sv =====
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the sorted time schedule table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_time_schedule_table_defines.svh"

module sts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);
  import sts_pkg::*;

  logic s_acc;
  logic m_stall;

  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // A stalled result holds its payload.
  `STS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_stall,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
                   "stalled result changed")

  // After taking an item, the block closes its input while it works on that item.
  `STS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_acc, !s_axis_tready_o,
                   "input taken while previous item still executing")

  // A fresh result follows an execute cycle, when the input side was closed.
  `STS_ASSERT_IMPL(a_result_after_exec, clk_i, rst_ni, $rose(m_axis_tvalid_o),
                   !$past(s_axis_tready_o),
                   "result appeared without an execute cycle")

  // A rejected insert reports position zero and no stored value.
  `STS_ASSERT_IMPL(a_reject_clean, clk_i, rst_ni,
                   m_axis_tvalid_o && (m_axis_tuser_o == STAT_REJECTED),
                   m_axis_tdata_o[36:0] == '0,
                   "rejected insert carries a position or value")

endmodule

bind sorted_time_schedule_table sts_checker u_sts_checker (.*);
